// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_CLK_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NORST(label, clk, prop)
`endif
`endif

// File: rtl/ccpv_pkg.sv
`default_nettype none
package ccpv_pkg;
  localparam int unsigned RootW  = 16;
  localparam int unsigned QuotW  = 14;
  localparam int unsigned NumW   = 30;
  localparam int unsigned SqW    = 32;
  localparam int unsigned PreSt  = 3;
  localparam int unsigned NumSt  = PreSt + RootW + QuotW;

  localparam logic CfgRadius = 1'b0;
  localparam logic CfgFilled = 1'b1;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [SqW-1:0]     sqx;
    logic [SqW-1:0]     sqy;
    logic [SqW-1:0]     r2;
    logic [SqW-1:0]     rem;
    logic [RootW-1:0]   root;
    logic [NumW-1:0]    remx;
    logic [NumW-1:0]    remy;
    logic [QuotW-1:0]   qx;
    logic [QuotW-1:0]   qy;
    logic               in_disc;
    logic               zero;
  } stage_t;
endpackage
`default_nettype wire

// File: rtl/circle_closest_point_vector_unit.sv
`default_nettype none
`include "assert_macros.svh"
// Closest point on a circle: for each word (reference point, circle centre) the unit
// returns the vector from the point to the nearest spot on the circle's brim, or zero
// with inside_area set when the point lies strictly inside a filled disc. One word is
// taken every cycle while the output is not stalled; the difference, square and sum
// stages feed a 16-stage square-root pipeline (one root bit per stage), then a 14-stage
// restoring divider (one quotient bit per stage) and the output register. A stall on the output
// freezes the whole pipeline. Write circle_radius and filled_mode only while idle.
module circle_closest_point_vector_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [13:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // ref_x[14:0], ref_y[29:15], center_x[44:30], center_y[59:45], zero fill
  input  wire logic [63:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // vec_x[15:0], vec_y[31:16]
  output logic [31:0]      m_tdata,
  // inside_area[0]
  output logic             m_tuser
);
  localparam int unsigned NSt = ccpv_pkg::NumSt;

  logic [13:0] circle_radius;
  logic        filled_mode;
  ccpv_pkg::stage_t p [NSt];
  logic [NSt-1:0] v;
  logic en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      circle_radius <= '0;
      filled_mode   <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_index == ccpv_pkg::CfgRadius) circle_radius <= cfg_data;
      else filled_mode <= cfg_data[0];
    end
  end

  // Advance every stage together unless the output word is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v        <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v        <= {v[NSt-2:0], s_tvalid};
      m_tvalid <= v[NSt-1];
    end
  end

  // Stage 0: differences
  ccpv_pkg::stage_t s0_next;
  always_comb begin
    s0_next    = '0;
    s0_next.dx = {s_tdata[44], s_tdata[44:30]} - {s_tdata[14], s_tdata[14:0]};
    s0_next.dy = {s_tdata[59], s_tdata[59:45]} - {s_tdata[29], s_tdata[29:15]};
  end
  always_ff @(posedge clk) begin
    if (en) p[0] <= s0_next;
  end

  // Stage 1: squares, radius square and numerators |d| * r
  logic [15:0] ax, ay;
  ccpv_pkg::stage_t s1_next;
  assign ax = p[0].dx[15] ? 16'(-p[0].dx) : 16'(p[0].dx);
  assign ay = p[0].dy[15] ? 16'(-p[0].dy) : 16'(p[0].dy);
  always_comb begin
    s1_next      = p[0];
    s1_next.sqx  = 32'(ax) * 32'(ax);
    s1_next.sqy  = 32'(ay) * 32'(ay);
    s1_next.r2   = 32'(circle_radius) * 32'(circle_radius);
    s1_next.remx = 30'(ax) * 30'(circle_radius);
    s1_next.remy = 30'(ay) * 30'(circle_radius);
  end
  always_ff @(posedge clk) begin
    if (en) p[1] <= s1_next;
  end

  // Stage 2: sum of squares and inside test
  logic [31:0] ssum;
  logic        ins;
  ccpv_pkg::stage_t s2_next;
  assign ssum = p[1].sqx + p[1].sqy;
  assign ins  = filled_mode && (ssum < p[1].r2);
  always_comb begin
    s2_next         = p[1];
    s2_next.rem     = ssum;
    s2_next.root    = '0;
    s2_next.in_disc = ins;
    s2_next.zero    = (ssum == '0) || ins;
  end
  always_ff @(posedge clk) begin
    if (en) p[2] <= s2_next;
  end

  // Square root, one bit per stage from the top
  for (genvar k = 0; k < ccpv_pkg::RootW; k++) begin : g_sqrt
    localparam int unsigned B = ccpv_pkg::RootW - 1 - k;
    localparam int unsigned I = ccpv_pkg::PreSt + k;
    logic [33:0] trial;
    logic        take;
    ccpv_pkg::stage_t nxt;
    assign trial = (34'(p[I-1].root) << (B + 1)) | (34'd1 << (2 * B));
    assign take  = {2'b00, p[I-1].rem} >= trial;
    always_comb begin
      nxt = p[I-1];
      if (take) begin
        nxt.rem  = 32'({2'b00, p[I-1].rem} - trial);
        nxt.root = p[I-1].root | (16'd1 << B);
      end
    end
    always_ff @(posedge clk) begin
      if (en) p[I] <= nxt;
    end
  end

  // Restoring division by the root, one quotient bit per stage
  for (genvar j = 0; j < ccpv_pkg::QuotW; j++) begin : g_div
    localparam int unsigned B = ccpv_pkg::QuotW - 1 - j;
    localparam int unsigned I = ccpv_pkg::PreSt + ccpv_pkg::RootW + j;
    logic [30:0] dsh;
    logic        tx, ty;
    ccpv_pkg::stage_t nxt;
    assign dsh = 31'(p[I-1].root) << B;
    assign tx  = {1'b0, p[I-1].remx} >= dsh;
    assign ty  = {1'b0, p[I-1].remy} >= dsh;
    always_comb begin
      nxt = p[I-1];
      if (tx) begin
        nxt.remx = 30'({1'b0, p[I-1].remx} - dsh);
        nxt.qx   = p[I-1].qx | (14'd1 << B);
      end
      if (ty) begin
        nxt.remy = 30'({1'b0, p[I-1].remy} - dsh);
        nxt.qy   = p[I-1].qy | (14'd1 << B);
      end
    end
    always_ff @(posedge clk) begin
      if (en) p[I] <= nxt;
    end
  end

  // Output register: zero for a zero or inside result, else d minus the signed quotient
  logic signed [15:0] qsx, qsy;
  assign qsx = p[NSt-1].dx[15] ? -$signed({2'b00, p[NSt-1].qx})
                               :  $signed({2'b00, p[NSt-1].qx});
  assign qsy = p[NSt-1].dy[15] ? -$signed({2'b00, p[NSt-1].qy})
                               :  $signed({2'b00, p[NSt-1].qy});
  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= p[NSt-1].in_disc;
      if (p[NSt-1].zero) m_tdata <= '0;
      else m_tdata <= {16'(p[NSt-1].dy - qsy), 16'(p[NSt-1].dx - qsx)};
    end
  end

  `ASSERT_CLK(a_inside_zero, clk, rst, m_tvalid && m_tuser |-> m_tdata == '0)
  `ASSERT_CLK(a_ring_no_inside, clk, rst, m_tvalid && !filled_mode |-> !m_tuser)
  `ASSERT_CLK(a_hold_on_stall, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata))
  `ASSERT_CLK(a_ready_rule, clk, rst, s_tready == (!m_tvalid || m_tready))
endmodule
`default_nettype wire
